// ----- rtl/mcln_pkg.sv -----
// Shared types and constants for the column Lp norm block.
package mcln_pkg;
   localparam int SUM_BITS = 64;
   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
   localparam logic [0:0] CMD_ACCUMULATE = 1'b0;
   localparam logic [0:0] CMD_FINISH = 1'b1;
   localparam logic [0:0] CSR_NORM_ORDER = 1'b0;
   localparam logic [0:0] CSR_COLUMNS = 1'b1;
   typedef logic [SUM_BITS-1:0] sum_type;
endpackage

// ----- rtl/matrix_column_lp_norm.sv -----
// Column Lp norm: a 64-bit sum of |value|^L per column, kept in one synchronous memory.
// An accumulate holds busy high after its transfer until the sum is written back: the memory
// read overlaps the power steps, each power step takes two passes through one 32x32
// multiplier, a further pass sees that the last step is done, and the write state stores the
// sum. A finish walks the columns in use. Each column passes a read state, a load state and
// an output state. For L above one it also takes a bit-serial root over 32 candidate bits,
// since the root of a 64-bit sum fits in 32 bits. For each bit the candidate is raised to
// the power L on the same multiplier, stopping early once the product exceeds the sum.
// Each column is written back to zero as it is read. The columns not in use are swept
// afterwards, with busy still high. Results come one per strobe on rsp_valid, and the
// receiver cannot stall them. After reset a clearing pass over all COLUMNS entries runs
// with busy high. Register writes are taken only while the block is idle.
module matrix_column_lp_norm #(
   parameter int COLUMNS = 64,
   parameter int MAX_ORDER = 4,
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [0:0]  req_cmd,
   input  logic [5:0]  req_column,
   input  logic signed [15:0] req_value,
   output logic        rsp_valid,
   output logic [5:0]  rsp_column_out,
   output logic [63:0] rsp_norm,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int CW = AW + 1;
   localparam int EW = $clog2(MAX_ORDER + 1);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_APOW  = 4'd3;
   localparam logic [3:0] S_AWR   = 4'd4;
   localparam logic [3:0] S_FRD   = 4'd5;
   localparam logic [3:0] S_FLD   = 4'd6;
   localparam logic [3:0] S_RBIT  = 4'd7;
   localparam logic [3:0] S_RMUL  = 4'd8;
   localparam logic [3:0] S_FOUT  = 4'd9;

   mcln_pkg::sum_type mem [COLUMNS];
   mcln_pkg::sum_type rd_data_ff;

   logic [3:0] state_ff, state_in;
   logic [2:0] order_ff;
   logic [6:0] cols_ff;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [15:0] mag_ff, mag_in;
   logic [EW-1:0] step_ff, step_in;
   mcln_pkg::sum_type acc_ff, acc_in;   // power product of value or root candidate
   mcln_pkg::sum_type sum_ff, sum_in;   // column sum under root
   mcln_pkg::sum_type root_ff, root_in;
   logic [31:0] cand_ff, cand_in;
   logic [63:0] hi_ff, hi_in;           // upper partial product
   logic mph_ff, mph_in;                // multiply pass: 0 upper half, 1 lower half
   logic [5:0] bit_ff, bit_in;
   logic [AW-1:0] wcol_ff, wcol_in;
   logic [AW-1:0] rd_addr;
   logic wr_en;
   logic [AW-1:0] wr_addr;
   mcln_pkg::sum_type wr_data;
   logic [63:0] rsp_norm_ff, rsp_norm_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [5:0] rsp_col_ff, rsp_col_in;

   logic [EW-1:0] eff_order;
   logic [CW-1:0] eff_cols;
   logic [VALUE_BITS-1:0] raw;
   logic [15:0] mag;
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   logic [95:0] prod;
   logic prod_ovf;
   mcln_pkg::sum_type sat_sum;
   logic [64:0] sum_wide;

   always_comb begin
      if (order_ff == 3'd0) eff_order = EW'(1);
      else if (32'(order_ff) > MAX_ORDER) eff_order = EW'(MAX_ORDER);
      else eff_order = EW'(order_ff);
      if (cols_ff == 7'd0) eff_cols = CW'(1);
      else if (32'(cols_ff) > COLUMNS) eff_cols = CW'(COLUMNS);
      else eff_cols = CW'(cols_ff);
   end

   assign raw = req_value[VALUE_BITS-1:0];
   assign mag = raw[VALUE_BITS-1] ? 16'(-{1'b0, raw}) & 16'((17'd1 << VALUE_BITS) - 17'd1)
                                    : 16'(raw);

   // A 64x32 product takes two passes: the upper half of acc first, then the lower half.
   always_comb begin
      mul_a = mph_ff ? acc_ff[31:0] : acc_ff[63:32];
      mul_b = (state_ff == S_APOW) ? {16'd0, mag_ff} : cand_ff;
      mul_p = 64'(mul_a) * 64'(mul_b);
      prod = {hi_ff, 32'd0} + {32'd0, mul_p};
      prod_ovf = |prod[95:64];
   end

   assign sum_wide = {1'b0, rd_data_ff} + {1'b0, acc_ff};
   assign sat_sum = sum_wide[64] ? mcln_pkg::SUM_MAX : sum_wide[63:0];

   always_comb begin
      state_in = state_ff; ptr_in = ptr_ff; mag_in = mag_ff; step_in = step_ff;
      acc_in = acc_ff; sum_in = sum_ff; root_in = root_ff; cand_in = cand_ff;
      hi_in = hi_ff; mph_in = mph_ff;
      bit_in = bit_ff; wcol_in = wcol_ff; rd_addr = wcol_ff;
      wr_en = 1'b0; wr_addr = wcol_ff; wr_data = '0;
      rsp_valid_in = 1'b0; rsp_last_in = 1'b0; rsp_col_in = rsp_col_ff;
      rsp_norm_in = rsp_norm_ff;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_addr = ptr_ff[AW-1:0];
            if (ptr_ff == CW'(COLUMNS - 1)) begin
               state_in = S_IDLE;
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + CW'(1);
            end
         end
         S_IDLE: begin
            if (start) begin
               if (req_cmd == mcln_pkg::CMD_FINISH) begin
                  ptr_in = '0; state_in = S_FRD;
               end else if (32'(req_column) < COLUMNS) begin
                  wcol_in = AW'(req_column); mag_in = mag;
                  acc_in = 64'd1; step_in = '0; mph_in = 1'b0; state_in = S_APOW;
               end
            end
         end
         S_APOW: begin
            rd_addr = wcol_ff;
            if (step_ff == eff_order) begin
               state_in = S_AWR;
            end else if (!mph_ff) begin
               hi_in = mul_p; mph_in = 1'b1;
            end else begin
               acc_in = prod_ovf ? mcln_pkg::SUM_MAX : prod[63:0];
               step_in = step_ff + EW'(1);
               mph_in = 1'b0;
            end
         end
         S_AWR: begin
            wr_en = 1'b1; wr_data = sat_sum; state_in = S_IDLE;
         end
         S_FRD: begin
            rd_addr = ptr_ff[AW-1:0];
            wr_en = 1'b1; wr_addr = ptr_ff[AW-1:0];
            state_in = S_FLD;
         end
         S_FLD: begin
            sum_in = rd_data_ff;
            if (eff_order == EW'(1)) begin
               root_in = rd_data_ff; state_in = S_FOUT;
            end else begin
               root_in = '0; bit_in = 6'd31;
               cand_in = 32'h8000_0000; state_in = S_RMUL;
               acc_in = 64'd1; step_in = '0; mph_in = 1'b0;
            end
         end
         S_RMUL: begin
            if (step_ff == eff_order) begin
               if (acc_ff <= sum_ff) root_in = 64'(cand_ff);
               state_in = S_RBIT;
            end else if (!mph_ff) begin
               hi_in = mul_p; mph_in = 1'b1;
            end else if (prod_ovf || prod[63:0] > sum_ff) begin
               mph_in = 1'b0;
               state_in = S_RBIT;
            end else begin
               acc_in = prod[63:0]; step_in = step_ff + EW'(1);
               mph_in = 1'b0;
            end
         end
         S_RBIT: begin
            if (bit_ff == 6'd0) begin
               state_in = S_FOUT;
            end else begin
               bit_in = bit_ff - 6'd1;
               cand_in = root_ff[31:0] | (32'd1 << (bit_ff - 6'd1));
               acc_in = 64'd1; step_in = '0; mph_in = 1'b0; state_in = S_RMUL;
            end
         end
         S_FOUT: begin
            rsp_valid_in = 1'b1; rsp_norm_in = root_ff;
            rsp_col_in = 6'(ptr_ff);
            rsp_last_in = (ptr_ff + CW'(1) == eff_cols);
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff + CW'(1) == eff_cols) begin
               state_in = (eff_cols == CW'(COLUMNS)) ? S_IDLE : S_CLEAR;
               if (eff_cols == CW'(COLUMNS)) ptr_in = '0;
            end else begin
               state_in = S_FRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign csr_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; ptr_ff <= '0;
         order_ff <= 3'd2; cols_ff <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ptr_ff <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready && csr_index == mcln_pkg::CSR_NORM_ORDER)
            order_ff <= csr_data[2:0];
         if (csr_valid && csr_ready && csr_index == mcln_pkg::CSR_COLUMNS)
            cols_ff <= csr_data[6:0];
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in; step_ff <= step_in; acc_ff <= acc_in; sum_ff <= sum_in;
      root_ff <= root_in; cand_ff <= cand_in; bit_ff <= bit_in; wcol_ff <= wcol_in;
      hi_ff <= hi_in; mph_ff <= mph_in;
      rsp_norm_ff <= rsp_norm_in; rsp_last_ff <= rsp_last_in; rsp_col_ff <= rsp_col_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_norm = rsp_norm_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_column_out = rsp_col_ff;
endmodule
